FILE: sv/tbpc_pkg.sv
// -----------------------------------------------------------------------------
// Two-button press classifier package
// Shared types, event codes, register indexes and reset values.
// -----------------------------------------------------------------------------
package tbpc_pkg;

   // Widths of the request fields and the configuration registers.
   localparam int TIME_W = 32;
   localparam int CSR_W  = 16;

   // Register reset values.
   localparam logic [CSR_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CSR_W-1:0] LONG_PRESS_RESET = 16'd3000;

   // Event codes reported with every response.
   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_BOTH_LONG    = 3'd1,
      EV_ID_SHORT     = 3'd2,
      EV_ID_LONG_END  = 3'd3,
      EV_EXEC_PRESS   = 3'd4,
      EV_EXEC_RELEASE = 3'd5
   } event_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_index_type;

   // One sample taken from the request channel.
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              id_pin_level;
      logic              exec_pin_level;
   } sample_type;

   // One response item.
   typedef struct packed {
      event_type         event_code;
      logic [TIME_W-1:0] exec_held_ms;
      logic              id_debounced;
      logic              exec_debounced;
   } result_type;

   // Configuration registers as seen by the classifier.
   typedef struct packed {
      logic [CSR_W-1:0] debounce_ms;
      logic [CSR_W-1:0] long_press_ms;
   } cfg_type;

   // Debounce and press timing state carried from one sample to the next.
   typedef struct packed {
      logic              id_pressed;
      logic              exec_pressed;
      logic [TIME_W-1:0] id_change_time;
      logic [TIME_W-1:0] exec_change_time;
      logic [TIME_W-1:0] id_press_start;
      logic              id_timing;
      logic [TIME_W-1:0] exec_press_start;
      logic              exec_timing;
      logic [TIME_W-1:0] both_start;
      logic              both_timing;
      logic              both_fired;
      logic [TIME_W-1:0] last_exec_duration;
   } btn_state_type;

endpackage

FILE: sv/two_button_press_classifier.sv
// -----------------------------------------------------------------------------
// Two-button press classifier
// Debounces an ID and an exec button and reports press events per sample.
// -----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel is one sample: a millisecond timestamp
//   and the two raw, active-low pin levels. Every request gives exactly one
//   response on the rsp_ channel: an event code, the duration of the last
//   completed exec press and both debounced button states.
//   The csr_ port writes the debounce time (index 0) and the long-press time
//   (index 1); write only while no request is in flight.
//   A request accepted on req_ is held in the sample register; when the
//   response register is free or drained, the classification logic writes
//   the response register and rsp_tvalid rises. Throughput is one request
//   per cycle while the receiver does not stall; the single classification
//   stage, which updates the button state, sets it.
//   When the receiver stalls, the response register holds its item and the
//   sample register still takes one more request; req_tready then falls
//   until the response moves on.
//   Reset clears all button state, empties both registers and loads the
//   register defaults: 50 ms debounce and 3000 ms long press.
// -----------------------------------------------------------------------------
module two_button_press_classifier
   import tbpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,   // now_ms[31:0], id_pin_level, exec_pin_level
   // Response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // event_code[2:0], exec_held_ms[31:0],
                                             // id_debounced, exec_debounced
   // Configuration write port
   input  logic                 csr_wr_en,
   input  csr_index_type        csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   logic          req_vld_ff;
   logic          req_vld_in;
   sample_type    sample_ff;
   logic          rsp_vld_ff;
   logic          rsp_vld_in;
   result_type    rsp_ff;
   btn_state_type state_ff;
   btn_state_type state_in;
   result_type    result;
   cfg_type       cfg_ff;
   logic          advance;

   // The pipeline moves whenever the response register is free or drained.
   assign advance    = ~rsp_vld_ff | rsp_tready;
   assign req_tready = ~req_vld_ff | advance;
   assign req_vld_in = (req_tvalid & req_tready) | (req_vld_ff & ~advance);
   assign rsp_vld_in = advance ? req_vld_ff : rsp_vld_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE:   cfg_ff.debounce_ms   <= csr_wr_data;
            CSR_LONG_PRESS: cfg_ff.long_press_ms <= csr_wr_data;
            default:        cfg_ff               <= cfg_ff;
         endcase
      end
   end

   // Sample register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
      if (req_tvalid && req_tready) begin
         sample_ff.now_ms         <= req_tdata[31:0];
         sample_ff.id_pin_level   <= req_tdata[32];
         sample_ff.exec_pin_level <= req_tdata[33];
      end
   end

   // Classification of the registered sample.
   tbpc_classify u_classify (
      .sample    (sample_ff),
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   // Button state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (advance && req_vld_ff) begin
            state_ff <= state_in;
         end
      end
      if (advance && req_vld_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.exec_debounced, rsp_ff.id_debounced,
                        rsp_ff.exec_held_ms, rsp_ff.event_code};

   // A both-long event is only reported while both buttons are held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_ff.event_code == EV_BOTH_LONG)
         |-> rsp_ff.id_debounced && rsp_ff.exec_debounced)
      else $error("both-long event without both buttons held");

   // An exec press is only reported with exec alone held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_ff.event_code == EV_EXEC_PRESS)
         |-> rsp_ff.exec_debounced && !rsp_ff.id_debounced)
      else $error("exec press reported without exec held alone");

   // A release event always comes with the button released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_ff.event_code == EV_EXEC_RELEASE || rsp_ff.event_code == EV_ID_SHORT
                     || rsp_ff.event_code == EV_ID_LONG_END)
         |-> (rsp_ff.event_code == EV_EXEC_RELEASE) ? !rsp_ff.exec_debounced
                                                    : !rsp_ff.id_debounced)
      else $error("release event while button still held");

   // The fired flag only stands while the both-hold timer runs.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.both_fired |-> state_ff.both_timing)
      else $error("both_fired set without both_timing");

   // The button state changes only when a sample moves to the response.
   assert property (@(posedge clock) disable iff (reset)
      !(advance && req_vld_ff) |=> $stable(state_ff))
      else $error("button state changed without a sample");

endmodule

FILE: sv/tbpc_classify.sv
// -----------------------------------------------------------------------------
// Two-button press classifier: per-sample logic
// Debounces both buttons and classifies one sample, giving the next state
// and the response for that sample.
// -----------------------------------------------------------------------------
module tbpc_classify
   import tbpc_pkg::*;
(
   input  sample_type    sample,
   input  btn_state_type state_cur,
   input  cfg_type       cfg,
   output btn_state_type state_nxt,
   output result_type    result
);

   logic              id_raw;
   logic              exec_raw;
   logic [TIME_W-1:0] id_since_change;
   logic [TIME_W-1:0] exec_since_change;
   logic [TIME_W-1:0] both_held;
   logic [TIME_W-1:0] id_held;
   logic [TIME_W-1:0] exec_held;
   logic [TIME_W-1:0] debounce_ext;
   logic [TIME_W-1:0] long_ext;

   // Pins are active low; all time differences wrap modulo 2^32.
   assign id_raw            = ~sample.id_pin_level;
   assign exec_raw          = ~sample.exec_pin_level;
   assign id_since_change   = sample.now_ms - state_cur.id_change_time;
   assign exec_since_change = sample.now_ms - state_cur.exec_change_time;
   assign both_held         = sample.now_ms - state_cur.both_start;
   assign id_held           = sample.now_ms - state_cur.id_press_start;
   assign exec_held         = sample.now_ms - state_cur.exec_press_start;
   assign debounce_ext      = {{(TIME_W-CSR_W){1'b0}}, cfg.debounce_ms};
   assign long_ext          = {{(TIME_W-CSR_W){1'b0}}, cfg.long_press_ms};

   always_comb begin
      logic      fired_now;
      event_type ev;

      state_nxt = state_cur;
      fired_now = 1'b0;
      ev        = EV_NONE;

      // Lockout debounce of each button.
      if ((id_raw != state_cur.id_pressed) && (id_since_change > debounce_ext)) begin
         state_nxt.id_pressed     = id_raw;
         state_nxt.id_change_time = sample.now_ms;
      end
      if ((exec_raw != state_cur.exec_pressed) && (exec_since_change > debounce_ext)) begin
         state_nxt.exec_pressed     = exec_raw;
         state_nxt.exec_change_time = sample.now_ms;
      end

      // Both buttons held: one long event per hold.
      if (state_nxt.id_pressed && state_nxt.exec_pressed) begin
         if (!state_cur.both_timing) begin
            state_nxt.both_start  = sample.now_ms;
            state_nxt.both_timing = 1'b1;
         end else if ((both_held >= long_ext) && !state_cur.both_fired) begin
            ev                    = EV_BOTH_LONG;
            state_nxt.both_fired  = 1'b1;
            fired_now             = 1'b1;
            state_nxt.id_timing   = 1'b0;
            state_nxt.exec_timing = 1'b0;
         end
      end else begin
         state_nxt.both_timing = 1'b0;
         state_nxt.both_fired  = 1'b0;
      end

      // Single-button logic; the exec event overrides the ID event.
      if (!fired_now) begin
         if (state_nxt.id_pressed && !state_nxt.exec_pressed) begin
            if (!state_cur.id_timing) begin
               state_nxt.id_press_start = sample.now_ms;
               state_nxt.id_timing      = 1'b1;
            end
         end else if (!state_nxt.id_pressed && state_cur.id_timing) begin
            ev                  = (id_held >= long_ext) ? EV_ID_LONG_END : EV_ID_SHORT;
            state_nxt.id_timing = 1'b0;
         end

         if (state_nxt.exec_pressed && !state_nxt.id_pressed) begin
            if (!state_cur.exec_timing) begin
               state_nxt.exec_press_start = sample.now_ms;
               state_nxt.exec_timing      = 1'b1;
               ev                         = EV_EXEC_PRESS;
            end
         end else if (!state_nxt.exec_pressed && state_cur.exec_timing) begin
            state_nxt.last_exec_duration = exec_held;
            state_nxt.exec_timing        = 1'b0;
            ev                           = EV_EXEC_RELEASE;
         end
      end

      result.event_code     = ev;
      result.exec_held_ms   = state_nxt.last_exec_duration;
      result.id_debounced   = state_nxt.id_pressed;
      result.exec_debounced = state_nxt.exec_pressed;
   end

endmodule
